/* hw/rtl/sisb_pkg.sv */
// shared types and constants for the slice index set builder
`timescale 1ns / 1ps

package sisb_pkg;

  localparam int MAX_ELEMENTS_DEFAULT = 256;
  localparam int COUNT_W = 9;
  localparam int VALUE_W = 16;
  localparam int POS_W = 8;
  localparam int ACTION_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_SINGLE = 2'd1,
    ACT_RANGE  = 2'd2,
    ACT_FETCH  = 2'd3
  } action_t;

endpackage

/* hw/rtl/sisb_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sisb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/slice_index_set_builder.sv */
// top level: membership bitmap of selected positions, built from index terms
//
// channel   signals                                     direction
// item      item_valid item_stall action first_value     in
//           range_end step_value
// result    result_valid result_stall position found     out
// cfg       cfg_valid cfg_ready element_count            in
//
// a single add passes S_WRAP, S_CLAMP (which writes) and S_DONE; a range add passes
// the same states plus S_WALK, one write per position the walk visits
// (a range that marks only its start is written in S_CLAMP and skips S_WALK)
// fetch scans the bitmap in S_FETCH (one ram read a cycle), then passes S_DONE
// clear sweeps the bitmap ram, one entry a cycle, then passes S_DONE; after reset
// the same sweep runs with item_stall high. a waiting result sits in the output
// register; the next item is taken meanwhile and holds only at its own end until the result is taken
`timescale 1ns / 1ps

module slice_index_set_builder #(
  parameter int MAX_ELEMENTS = sisb_pkg::MAX_ELEMENTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [sisb_pkg::ACTION_W-1:0]       action,
  input  logic signed [sisb_pkg::VALUE_W-1:0] first_value,
  input  logic signed [sisb_pkg::VALUE_W-1:0] range_end,
  input  logic signed [sisb_pkg::VALUE_W-1:0] step_value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [sisb_pkg::POS_W-1:0]          position,
  output logic                                found,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sisb_pkg::COUNT_W-1:0]        element_count
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int NW = (CW > sisb_pkg::COUNT_W) ? CW : sisb_pkg::COUNT_W;
  localparam int WW = ((NW > sisb_pkg::VALUE_W) ? NW : sisb_pkg::VALUE_W) + 2;
  localparam logic signed [WW-1:0] OneS = WW'(1);
  localparam logic signed [WW-1:0] ZeroS = '0;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_WRAP  = 7'b0000100,
    S_CLAMP = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_FETCH = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic [sisb_pkg::COUNT_W-1:0] elem_count;
  sisb_pkg::action_t            act_reg;
  logic signed [sisb_pkg::VALUE_W-1:0] first_reg;
  logic signed [sisb_pkg::VALUE_W-1:0] end_reg;
  logic signed [sisb_pkg::VALUE_W-1:0] step_reg;

  logic [AW-1:0] clr_addr;
  logic          clr_item;
  logic [CW-1:0] cursor;
  logic [CW-1:0] scan_addr;
  logic [AW-1:0] chk_pos;
  logic          rd_pending;

  logic signed [WW-1:0] s_w;
  logic signed [WW-1:0] e_w;
  logic signed [WW-1:0] step_norm;
  logic signed [WW-1:0] walk_pos;
  logic signed [WW-1:0] walk_end;
  logic                 walk_up;

  logic [sisb_pkg::POS_W-1:0] res_pos;
  logic                       res_found;

  // combinational helpers
  logic [WW-1:0]        cnt_ext;
  logic [WW-1:0]        max_ext;
  logic signed [WW-1:0] n_s;
  logic signed [WW-1:0] first_ext;
  logic signed [WW-1:0] end_ext;
  logic signed [WW-1:0] step_ext;
  logic signed [WW-1:0] s_wrap;
  logic signed [WW-1:0] e_wrap;
  logic signed [WW-1:0] st_norm;
  logic signed [WW-1:0] cs;
  logic signed [WW-1:0] ce;
  logic                 skip;
  logic                 only_start;
  logic                 single_ok;
  logic signed [WW-1:0] walk_next;
  logic                 walk_more;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_data;
  logic          rd_en;
  logic          rd_data;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);

  always_comb begin
    cnt_ext   = WW'(elem_count);
    max_ext   = WW'(MAX_ELEMENTS);
    n_s       = signed'((cnt_ext > max_ext) ? max_ext : cnt_ext);
    first_ext = WW'(first_reg);
    end_ext   = WW'(end_reg);
    step_ext  = WW'(step_reg);

    s_wrap = (first_ext < ZeroS) ? first_ext + n_s : first_ext;
    e_wrap = (end_ext < ZeroS) ? end_ext + n_s : end_ext;
    if (step_ext > ZeroS) begin
      st_norm = step_ext;
    end else if ((-step_ext) < n_s) begin
      st_norm = step_ext + n_s;
    end else begin
      st_norm = OneS;
    end

    skip = (n_s == ZeroS) || ((s_w < ZeroS) && (e_w < ZeroS)) ||
           ((s_w >= n_s) && (e_w >= n_s));
    cs = (s_w >= n_s) ? n_s - OneS : ((s_w < ZeroS) ? ZeroS : s_w);
    ce = (e_w >= n_s) ? n_s - OneS : ((e_w < ZeroS) ? ZeroS : e_w);
    only_start = (cs == ce) || (step_ext >= n_s);
    single_ok  = (s_w >= ZeroS) && (s_w < n_s);

    // shared step adder for the walk
    walk_next = walk_up ? walk_pos + step_norm : walk_pos - step_norm;
    walk_more = walk_up ? (walk_next <= walk_end) : (walk_next >= walk_end);
  end

  // ram port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = 1'b0;
    rd_en   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_CLAMP: begin
        if (act_reg == sisb_pkg::ACT_SINGLE) begin
          wr_en = single_ok;
        end else begin
          wr_en = !skip && only_start;
        end
        wr_addr = (act_reg == sisb_pkg::ACT_SINGLE) ? s_w[AW-1:0] : cs[AW-1:0];
        wr_data = 1'b1;
      end
      S_WALK: begin
        wr_en   = 1'b1;
        wr_addr = walk_pos[AW-1:0];
        wr_data = 1'b1;
      end
      S_FETCH: begin
        rd_en = !(rd_pending && rd_data) && (scan_addr != CW'(MAX_ELEMENTS));
      end
      S_IDLE, S_WRAP, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  sisb_ram #(
    .WIDTH(1),
    .DEPTH(MAX_ELEMENTS)
  ) u_map (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(scan_addr[AW-1:0]),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      clr_item     <= 1'b0;
      cursor       <= '0;
      rd_pending   <= 1'b0;
      result_valid <= 1'b0;
      elem_count   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        elem_count <= element_count;
      end
      // in S_DONE the output register is reloaded below instead
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(MAX_ELEMENTS - 1)) begin
            state    <= clr_item ? S_DONE : S_IDLE;
            clr_item <= 1'b0;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            act_reg   <= sisb_pkg::action_t'(action);
            first_reg <= first_value;
            end_reg   <= range_end;
            step_reg  <= step_value;
            res_pos   <= '0;
            res_found <= 1'b0;
            case (sisb_pkg::action_t'(action))
              sisb_pkg::ACT_CLEAR: begin
                state    <= S_CLEAR;
                clr_addr <= '0;
                clr_item <= 1'b1;
                cursor   <= '0;
              end
              sisb_pkg::ACT_FETCH: begin
                state      <= S_FETCH;
                scan_addr  <= cursor;
                rd_pending <= 1'b0;
              end
              default: begin
                state <= S_WRAP;
              end
            endcase
          end
        end
        S_WRAP: begin
          s_w       <= s_wrap;
          e_w       <= e_wrap;
          step_norm <= st_norm;
          state     <= S_CLAMP;
        end
        S_CLAMP: begin
          if (act_reg == sisb_pkg::ACT_SINGLE || skip || only_start) begin
            state <= S_DONE;
          end else begin
            walk_pos <= cs;
            walk_end <= ce;
            walk_up  <= (ce > cs);
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          walk_pos <= walk_next;
          if (!walk_more) begin
            state <= S_DONE;
          end
        end
        S_FETCH: begin
          if (rd_pending && rd_data) begin
            res_pos    <= sisb_pkg::POS_W'(chk_pos);
            res_found  <= 1'b1;
            cursor     <= CW'(chk_pos) + CW'(1);
            rd_pending <= 1'b0;
            state      <= S_DONE;
          end else if (scan_addr == CW'(MAX_ELEMENTS)) begin
            rd_pending <= 1'b0;
            state      <= S_DONE;
          end else begin
            chk_pos    <= scan_addr[AW-1:0];
            rd_pending <= 1'b1;
            scan_addr  <= scan_addr + CW'(1);
          end
        end
        S_DONE: begin
          // wait here only while the previous result is still held
          if (!result_valid || !result_stall) begin
            position     <= res_pos;
            found        <= res_found;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sim/tb_slice_index_set_builder.sv */
// self-checking testbench for slice_index_set_builder: directed and random index terms
`timescale 1ns / 1ps

module tb_slice_index_set_builder;
  import sisb_pkg::*;

  localparam int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    action_t                    act;
    logic signed [VALUE_W-1:0]  start_v;
    logic signed [VALUE_W-1:0]  end_v;
    logic signed [VALUE_W-1:0]  step_v;
  } term_t;

  typedef struct {
    logic [POS_W-1:0] pos;
    logic             hit;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [ACTION_W-1:0] action = ACT_CLEAR;
  logic signed [VALUE_W-1:0] first_value = '0;
  logic signed [VALUE_W-1:0] range_end = '0;
  logic signed [VALUE_W-1:0] step_value = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [POS_W-1:0] position;
  logic found;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] element_count = '0;

  slice_index_set_builder #(.MAX_ELEMENTS(MAX_ELEMENTS)) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .action(action),
    .first_value(first_value),
    .range_end(range_end),
    .step_value(step_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .position(position),
    .found(found),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .element_count(element_count)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [MAX_ELEMENTS-1:0] sel_map = '0;
  int unsigned             cursor = 0;
  logic [COUNT_W-1:0]      count_q = '0;

  term_t term_queue[$];
  pick_t want_queue[$];
  term_t cur_term;
  logic  item_taken = 1'b0;
  bit    no_idle = 1'b0;
  int    err_count = 0;
  int    quiet_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic void mark_pos(input int p);
    if (p >= 0 && p < MAX_ELEMENTS) sel_map[p] = 1'b1;
  endfunction

  function automatic void mark_single(input int v, input int n);
    if (v >= 0 && v < n) begin
      mark_pos(v);
    end else if (v < 0 && n >= -v) begin
      mark_pos(v + n);
    end
  endfunction

  function automatic void mark_range(input int s, input int e, input int st, input int n);
    int stride;
    int i;
    if (n <= 0) return;
    if (s < 0) s += n;
    if (e < 0) e += n;
    if ((s < 0 && e < 0) || (s >= n && e >= n)) return;
    if (s >= n) s = n - 1;
    else if (s < 0) s = 0;
    if (e >= n) e = n - 1;
    else if (e < 0) e = 0;
    if (s == e || st >= n) begin
      mark_pos(s);
      return;
    end
    if (st > 0) stride = st;
    else if (-st < n) stride = st + n;
    else stride = 1;
    if (e > s) begin
      for (i = s; i <= e; i += stride) mark_pos(i);
    end else begin
      for (i = s; i >= e; i -= stride) mark_pos(i);
    end
  endfunction

  function automatic pick_t apply_term(input term_t t);
    pick_t r;
    int n;
    int p;
    n = (count_q > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(count_q);
    r.pos = '0;
    r.hit = 1'b0;
    case (t.act)
      ACT_CLEAR: begin
        sel_map = '0;
        cursor = 0;
      end
      ACT_SINGLE: mark_single(int'(t.start_v), n);
      ACT_RANGE: mark_range(int'(t.start_v), int'(t.end_v), int'(t.step_v), n);
      default: begin
        for (p = int'(cursor); p < MAX_ELEMENTS && !r.hit; p++) begin
          if (sel_map[p]) begin
            r.pos = POS_W'(p);
            r.hit = 1'b1;
            cursor = p + 1;
          end
        end
      end
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    item_taken <= item_valid && !item_stall;
    if (!rst && item_valid && !item_stall) begin
      want_queue.insert(want_queue.size(), apply_term(cur_term));
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (term_queue.size() != 0 && (no_idle || $urandom_range(99) >= 28)) begin
        cur_term = term_queue.pop_front();
        item_valid <= 1'b1;
        action <= cur_term.act;
        first_value <= cur_term.start_v;
        range_end <= cur_term.end_v;
        step_value <= cur_term.step_v;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pick_t w;
    if (!rst && result_valid && !result_stall) begin
      if (want_queue.size() == 0) begin
        report_mismatch("unexpected result, position", position, 0);
      end else begin
        w = want_queue.pop_front();
        if (position !== w.pos) report_mismatch("position", position, w.pos);
        if (found !== w.hit) report_mismatch("found", found, w.hit);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= !no_idle && ($urandom_range(99) < 28);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("slice_index_set_builder regression: fail");
      $finish;
    end
  end

  task automatic push_term(input action_t act, input int a, input int b, input int c);
    term_t t;
    t.act = act;
    t.start_v = a[VALUE_W-1:0];
    t.end_v = b[VALUE_W-1:0];
    t.step_v = c[VALUE_W-1:0];
    term_queue.insert(term_queue.size(), t);
  endtask

  task automatic wait_drained();
    while (term_queue.size() != 0 || item_valid || want_queue.size() != 0) @(negedge clk);
  endtask

  task automatic write_count(input int v);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    element_count <= v[COUNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    count_q = v[COUNT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_value(input int n);
    case ($urandom_range(9))
      0, 1: return int'($urandom_range(65535)) - 32768;
      2: return $urandom_range(1) ? 32767 : -32768;
      3: return $urandom_range(1) ? n : -n - 1;
      default: return int'($urandom_range(2 * n + 1)) - n - 1;
    endcase
  endfunction

  function automatic int pick_step(input int n);
    case ($urandom_range(7))
      0: return int'($urandom_range(65535)) - 32768;
      1: return 0;
      2: return -int'($urandom_range(n + 2));
      3: return n + int'($urandom_range(3));
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // usually a clear, then a few adds, then fetches; a share of the sequences is plain noise
  task automatic push_random_sequence(input int n);
    int k;
    if ($urandom_range(99) < 25) begin
      repeat ($urandom_range(1, 6)) begin
        push_term(action_t'($urandom_range(3)), pick_value(n), pick_value(n), pick_step(n));
      end
    end else begin
      if ($urandom_range(99) < 80) push_term(ACT_CLEAR, pick_value(n), pick_value(n), 0);
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(1)) push_term(ACT_SINGLE, pick_value(n), pick_value(n), pick_step(n));
        else push_term(ACT_RANGE, pick_value(n), pick_value(n), pick_step(n));
      end
      k = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      repeat (k) push_term(ACT_FETCH, pick_value(n), pick_value(n), pick_step(n));
    end
  endtask

  initial begin
    int n;
    int phase;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // count of zero: adds mark nothing
    write_count(0);
    push_term(ACT_SINGLE, 0, 0, 0);
    push_term(ACT_RANGE, -1, 5, 1);
    push_term(ACT_FETCH, 0, 0, 0);

    write_count(10);
    push_term(ACT_SINGLE, 9, 0, 0);
    push_term(ACT_SINGLE, 10, 0, 0);
    push_term(ACT_SINGLE, -10, 0, 0);
    push_term(ACT_SINGLE, -11, 0, 0);
    push_term(ACT_SINGLE, -32768, 0, 0);
    push_term(ACT_RANGE, -20, -15, 1);     // both ends below zero
    push_term(ACT_RANGE, 10, 32767, 1);    // both ends past the count
    push_term(ACT_RANGE, -30, 40, 3);      // clamped both ends
    push_term(ACT_RANGE, 4, 4, 2);         // equal ends
    push_term(ACT_RANGE, 2, 8, 10);        // step at least the count
    push_term(ACT_RANGE, 1, 7, -8);        // negative step wraps
    push_term(ACT_RANGE, 7, 1, -32768);    // step far negative becomes one, downward walk
    repeat (3) push_term(ACT_FETCH, -1, -1, -1);
    push_term(ACT_CLEAR, 0, 0, 0);
    push_term(ACT_SINGLE, 5, 0, 0);
    push_term(ACT_FETCH, 0, 0, 0);
    push_term(ACT_SINGLE, 2, 0, 0);        // behind the cursor
    push_term(ACT_FETCH, 0, 0, 0);         // exhausted

    // count above capacity saturates
    write_count(511);
    push_term(ACT_SINGLE, -1, 0, 0);
    push_term(ACT_RANGE, -600, 32767, 0);
    repeat (2) push_term(ACT_FETCH, 0, 0, 0);

    for (phase = 0; phase < 14; phase++) begin
      case ($urandom_range(7))
        0: n = MAX_ELEMENTS;
        1: n = $urandom_range(MAX_ELEMENTS + 1, 511);
        2: n = $urandom_range(0, 2);
        default: n = $urandom_range(1, 40);
      endcase
      write_count(n);
      no_idle = (phase == 5);
      while (term_queue.size() < 55) push_random_sequence(n);
      // hold the sender until every result is back
      if (phase == 3) wait_drained();
      while (term_queue.size() < 100) push_random_sequence(n);
    end

    wait_drained();
    no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (want_queue.size() != 0) report_mismatch("results missing", 0, want_queue.size());
    if (err_count == 0) begin
      $display("slice_index_set_builder regression: pass");
    end else begin
      $display("slice_index_set_builder regression: fail");
    end
    $finish;
  end

endmodule
